@@ rtl/imconv_pkg.sv @@
// ----------------------------------------------------------------------------
// imconv_pkg
// Shared types and constants of the 2-D image convolution unit.
// ----------------------------------------------------------------------------
package imconv_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_SIZE  = 3'd2;
  localparam logic [2:0] REG_KERNEL_ROW_0 = 3'd3;
  localparam logic [2:0] REG_KERNEL_ROW_1 = 3'd4;
  localparam logic [2:0] REG_KERNEL_ROW_2 = 3'd5;
  localparam logic [2:0] REG_KERNEL_ROW_3 = 3'd6;
  localparam logic [2:0] REG_KERNEL_ROW_4 = 3'd7;

  localparam int COEF_ROWS  = 5;
  localparam int COEF_COLS  = 5;
  localparam int COEF_W     = 12;
  localparam int ROW_W      = COEF_COLS * COEF_W;
  localparam int DIM_W      = 11;
  localparam int KSIZE_W    = 3;
  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  localparam int FRAC_BITS  = 8;
  localparam int PROD_W     = PIX_W + 1 + COEF_W;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             drain;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]                    image_width;
    logic [DIM_W-1:0]                    image_height;
    logic [KSIZE_W-1:0]                  kernel_size;
    logic [COEF_ROWS-1:0][ROW_W-1:0]     kernel_row;
  } cfg_t;

  // Work command from front to back
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             has_pixel;
    logic             emit;
    logic             last;
    logic             interior;
  } cmd_t;

endpackage

@@ rtl/imconv_ram.sv @@
// ----------------------------------------------------------------------------
// imconv_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module imconv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ rtl/imconv_queue.sv @@
// ----------------------------------------------------------------------------
// imconv_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module imconv_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  imconv_pkg::cmd_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output imconv_pkg::cmd_t  head
);

  localparam int AW = $clog2(imconv_pkg::QUEUE_DEPTH);

  imconv_pkg::cmd_t slots [imconv_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full       = (count == (AW+1)'(imconv_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/imconv_front.sv @@
// ----------------------------------------------------------------------------
// imconv_front
// Accepts items, tracks input and output positions and decides for each
// item whether it stores a pixel and whether it releases an output.
// ----------------------------------------------------------------------------
module imconv_front #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  imconv_pkg::in_item_t in_data,
  input  imconv_pkg::cfg_t     cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output imconv_pkg::cmd_t     q_data
);

  localparam int HALF = MAX_KERNEL / 2;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int DW   = $clog2(HALF * MAX_WIDTH + HALF + 2);

  logic [CW-1:0] in_col;
  logic [HW-1:0] in_row;
  logic [CW-1:0] out_col;
  logic [HW-1:0] out_row;
  logic [DW-1:0] lead;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [DW-1:0] lag;
  logic [DW-1:0] lead_next;
  logic [1:0]    n;
  logic          usable;
  logic          acc;
  logic          complete;
  logic          push;
  logic          in_col_last;
  logic          complete_after;
  logic          ready;
  logic          emit;
  logic          out_last;
  logic          interior;

  // Clamp frame sizes
  always_comb begin
    if (cfg.image_width == '0) begin
      w = WW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = HW'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(cfg.image_height);
    end
  end

  assign lag    = DW'(HALF) * DW'(w) + DW'(HALF);
  assign n      = cfg.kernel_size[2:1];
  assign usable = cfg.kernel_size[0] && (32'(cfg.kernel_size) <= 32'(MAX_KERNEL));

  // Classify the item
  assign acc            = in_valid && !q_full;
  assign complete       = (in_row == h);
  assign push           = acc && !in_data.drain && !complete;
  assign in_col_last    = ((WW+1)'(in_col) + 1'b1 == (WW+1)'(w));
  assign complete_after = complete || (push && in_col_last && (in_row + 1'b1 == h));
  assign lead_next      = lead + DW'(push);
  assign ready          = complete_after || (lead_next > lag);
  assign emit           = acc && ready;
  assign out_last       = ((WW+1)'(out_col) + 1'b1 == (WW+1)'(w)) && (out_row + 1'b1 == h);

  // Border test for the output position
  assign interior = usable
                 && ((HW+1)'(out_row) >= (HW+1)'(n))
                 && ((HW+1)'(out_row) + (HW+1)'(n) < (HW+1)'(h))
                 && ((WW+1)'(out_col) >= (WW+1)'(n))
                 && ((WW+1)'(out_col) + (WW+1)'(n) < (WW+1)'(w));

  assign in_stall           = q_full;
  assign q_push             = push || emit;
  assign q_data.pixel       = in_data.pixel_in;
  assign q_data.has_pixel   = push;
  assign q_data.emit        = emit;
  assign q_data.last        = out_last;
  assign q_data.interior    = interior;

  // Advance positions
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      lead    <= '0;
    end else if (acc) begin
      if (emit && out_last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        lead    <= '0;
      end else begin
        if (push) begin
          if (in_col_last) begin
            in_col <= '0;
            in_row <= in_row + 1'b1;
          end else begin
            in_col <= in_col + 1'b1;
          end
        end
        if (emit) begin
          if ((WW+1)'(out_col) + 1'b1 == (WW+1)'(w)) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
        lead <= lead_next - DW'(emit);
      end
    end
  end

endmodule

@@ rtl/imconv_back.sv @@
// ----------------------------------------------------------------------------
// imconv_back
// Line buffers, sliding window and multiply-accumulate pipeline. Each
// command pushes one or more columns into the window; output commands are aligned
// with extra flush pushes at the frame tail.
// ----------------------------------------------------------------------------
module imconv_back #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  imconv_pkg::cfg_t      cfg,
  input  logic                  q_valid,
  input  imconv_pkg::cmd_t      q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output imconv_pkg::out_item_t out_data
);

  localparam int HALF = MAX_KERNEL / 2;
  localparam int WIN  = 2 * HALF + 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int DW   = $clog2(HALF * MAX_WIDTH + HALF + 2);
  localparam int PW   = imconv_pkg::PROD_W;
  localparam int SW   = PW + $clog2(WIN * WIN) + 1;
  localparam int PXW  = imconv_pkg::PIX_W;
  localparam int CFW  = imconv_pkg::COEF_W;
  localparam logic signed [SW-1:0] SAT_HI =
    SW'(imconv_pkg::PIX_MAX << imconv_pkg::FRAC_BITS);
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1 << (imconv_pkg::FRAC_BITS - 1));

  logic [WW-1:0] w;
  logic [DW-1:0] lag;
  logic          en;
  logic          go;
  logic          aligned;
  logic          emit_now;
  logic          frame_done;
  logic [PXW-1:0] push_pixel;
  logic [CW-1:0]  col_next;
  logic           col_last;

  logic [CW-1:0]  lb_col;
  logic [DW-1:0]  lead;
  logic           done;

  logic [PXW-1:0] tap     [WIN];
  logic [PXW-1:0] win     [WIN][WIN];
  logic signed [CFW-1:0] coef [WIN][WIN];
  logic           coef_on [WIN][WIN];

  logic           s0_valid;
  logic           s0_last;
  logic           s0_interior;
  logic           s1_valid;
  logic           s1_last;
  logic           s1_interior;
  logic [PXW-1:0] s1_center;
  logic signed [PW-1:0] s1_prod [WIN][WIN];
  logic signed [SW-1:0] row_sum [WIN];
  logic           s2_valid;
  logic           s2_last;
  logic           s2_interior;
  logic [PXW-1:0] s2_center;
  logic signed [SW-1:0] s2_row [WIN];
  logic signed [SW-1:0] total_sum;
  logic           s3_valid;
  logic           s3_last;
  logic           s3_interior;
  logic [PXW-1:0] s3_center;
  logic signed [SW-1:0] s3_sum;
  logic signed [SW-1:0] s3_round;
  logic           s4_valid;
  imconv_pkg::out_item_t s4_data;

  // Clamp width
  always_comb begin
    if (cfg.image_width == '0) begin
      w = WW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.image_width);
    end
  end

  assign lag = DW'(HALF) * DW'(w) + DW'(HALF);

  // Command handling: every cycle with a command pushes one column
  assign en         = !(s4_valid && out_stall);
  assign go         = en && q_valid;
  assign aligned    = (lead == lag);
  assign emit_now   = go && q_head.emit && aligned;
  assign q_pop      = go && (!q_head.emit || aligned);
  assign frame_done = emit_now && q_head.last;
  assign push_pixel = (q_head.has_pixel && !done) ? q_head.pixel : '0;
  assign col_last   = ((WW+1)'(lb_col) + 1'b1 == (WW+1)'(w));

  always_comb begin
    if (go && frame_done) begin
      col_next = '0;
    end else if (go) begin
      col_next = col_last ? '0 : lb_col + 1'b1;
    end else begin
      col_next = lb_col;
    end
  end

  // Column taps: newest pixel, then one row older per line buffer
  assign tap[0] = push_pixel;

  for (genvar k = 0; k < WIN - 1; k++) begin : g_line
    logic [PXW-1:0] rd_raw;
    logic [PXW-1:0] byp_data;
    logic           byp_valid;

    imconv_ram #(
      .WIDTH(PXW),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk  (clk),
      .we   (go),
      .waddr(lb_col),
      .wdata(tap[k]),
      .raddr(col_next),
      .rdata(rd_raw)
    );

    // Forward a write that hit the address read in the same cycle
    always_ff @(posedge clk) begin
      if (rst) begin
        byp_valid <= 1'b0;
      end else begin
        byp_valid <= go && (col_next == lb_col);
      end
    end

    always_ff @(posedge clk) begin
      byp_data <= tap[k];
    end

    assign tap[k+1] = byp_valid ? byp_data : rd_raw;
  end

  // Track column, alignment and partial push of the head command
  always_ff @(posedge clk) begin
    if (rst) begin
      lb_col <= '0;
      lead   <= '0;
      done   <= 1'b0;
    end else if (go) begin
      lb_col <= col_next;
      if (frame_done) begin
        lead <= '0;
      end else begin
        lead <= lead + DW'(!emit_now);
      end
      if (q_pop) begin
        done <= 1'b0;
      end else if (q_head.has_pixel) begin
        done <= 1'b1;
      end
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
        win[i][WIN-1] <= tap[WIN-1-i];
      end
    end
  end

  // Select coefficients centered on the window; mark the taps in use
  always_comb begin
    int nk;
    int ki;
    int kj;
    nk = int'(cfg.kernel_size[2:1]);
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        ki = i - HALF + nk;
        kj = j - HALF + nk;
        if (ki >= 0 && kj >= 0 && ki < int'(cfg.kernel_size) && kj < int'(cfg.kernel_size)
            && ki < imconv_pkg::COEF_ROWS && kj < imconv_pkg::COEF_COLS) begin
          coef[i][j]    = cfg.kernel_row[ki][kj*CFW +: CFW];
          coef_on[i][j] = 1'b1;
        end else begin
          coef[i][j]    = '0;
          coef_on[i][j] = 1'b0;
        end
      end
    end
  end

  // Row sums of the products and total of the row sums
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        row_sum[i] = row_sum[i] + SW'(s1_prod[i][j]);
      end
    end
    total_sum = '0;
    for (int i = 0; i < WIN; i++) begin
      total_sum = total_sum + s2_row[i];
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= emit_now;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  assign s3_round = s3_sum + ROUND_HALF;

  // Multiply, sum rows, sum all, clamp and round
  always_ff @(posedge clk) begin
    if (en) begin
      s0_last     <= q_head.last;
      s0_interior <= q_head.interior;

      s1_last     <= s0_last;
      s1_interior <= s0_interior;
      s1_center   <= win[HALF][HALF];
      // Taps outside the kernel contribute nothing, whatever they hold
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          if (coef_on[i][j]) begin
            s1_prod[i][j] <= $signed({1'b0, win[i][j]}) * coef[i][j];
          end else begin
            s1_prod[i][j] <= '0;
          end
        end
      end

      s2_last     <= s1_last;
      s2_interior <= s1_interior;
      s2_center   <= s1_center;
      for (int i = 0; i < WIN; i++) begin
        s2_row[i] <= row_sum[i];
      end

      s3_last     <= s2_last;
      s3_interior <= s2_interior;
      s3_center   <= s2_center;
      s3_sum      <= total_sum;

      s4_data.frame_end <= s3_last;
      if (!s3_interior) begin
        s4_data.pixel_out <= s3_center;
      end else if (s3_sum < 0) begin
        s4_data.pixel_out <= '0;
      end else if (s3_sum > SAT_HI) begin
        s4_data.pixel_out <= PXW'(imconv_pkg::PIX_MAX);
      end else begin
        s4_data.pixel_out <= s3_round[imconv_pkg::FRAC_BITS +: PXW];
      end
    end
  end

  assign out_valid = s4_valid;
  assign out_data  = s4_data;

endmodule

@@ rtl/image_convolution_2d_unit.sv @@
// ----------------------------------------------------------------------------
// image_convolution_2d_unit
// Streaming 2-D convolution of 8-bit pixels with an odd square kernel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one item per clock unless in_stall is high,
// and leave one per clock once the window has filled unless out_stall is
// high. Output pixel p appears after input p plus (MAX_KERNEL/2) rows and
// (MAX_KERNEL/2) pixels has arrived; drain items then flush the tail of the
// frame. Interior results are the Q4.8 weighted sum, clamped to 0..255 and
// rounded half up; border pixels, and all pixels when the kernel size is
// zero, even or too large, pass through. After the aligning item is
// accepted, its result passes the command queue, then the window push,
// multiply, row sums, total and clamp registers. Frames of no more than
// (MAX_KERNEL/2) rows plus (MAX_KERNEL/2) pixels spend extra internal flush
// pushes on their last pixel until the window is aligned. MAX_KERNEL-1 line
// buffers of MAX_WIDTH pixels hold the past rows; no clearing is needed.
// ----------------------------------------------------------------------------
module image_convolution_2d_unit #(
  parameter int MAX_KERNEL = 5,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  imconv_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output imconv_pkg::out_item_t               out_data,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [imconv_pkg::ROW_W-1:0]        cfg_wdata
);

  imconv_pkg::cfg_t cfg;
  logic             q_full;
  logic             q_push;
  imconv_pkg::cmd_t q_data;
  logic             q_pop;
  logic             q_valid;
  imconv_pkg::cmd_t q_head;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= imconv_pkg::DIM_W'(1024);
      cfg.image_height <= imconv_pkg::DIM_W'(1024);
      cfg.kernel_size  <= imconv_pkg::KSIZE_W'(3);
      cfg.kernel_row   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        imconv_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_wdata[imconv_pkg::DIM_W-1:0];
        imconv_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_wdata[imconv_pkg::DIM_W-1:0];
        imconv_pkg::REG_KERNEL_SIZE:  cfg.kernel_size  <= cfg_wdata[imconv_pkg::KSIZE_W-1:0];
        imconv_pkg::REG_KERNEL_ROW_0: cfg.kernel_row[0] <= cfg_wdata;
        imconv_pkg::REG_KERNEL_ROW_1: cfg.kernel_row[1] <= cfg_wdata;
        imconv_pkg::REG_KERNEL_ROW_2: cfg.kernel_row[2] <= cfg_wdata;
        imconv_pkg::REG_KERNEL_ROW_3: cfg.kernel_row[3] <= cfg_wdata;
        imconv_pkg::REG_KERNEL_ROW_4: cfg.kernel_row[4] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  imconv_front #(
    .MAX_KERNEL(MAX_KERNEL),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .cfg     (cfg),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  imconv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head      (q_head)
  );

  imconv_back #(
    .MAX_KERNEL(MAX_KERNEL),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 2-D image convolution unit.
// ----------------------------------------------------------------------------
// Whole frames of random pixels are streamed through the unit under many
// frame sizes, kernel sizes and coefficient sets. Each accepted item runs
// through a local line-history predictor. Each output pixel is compared with
// the oldest predicted one. Both handshake sides idle at random, with one
// long output hold-off and one sender pause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF       = 2;
  localparam int MAX_DIM    = 1024;
  localparam int HIST_DEPTH = 2 * HALF * MAX_DIM + 2 * HALF + 1;
  localparam int SETTLE     = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  imconv_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  imconv_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = imconv_pkg::REG_IMAGE_WIDTH;
  logic [imconv_pkg::ROW_W-1:0] cfg_wdata = '0;

  image_convolution_2d_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor state and its copy of the registers
  logic [imconv_pkg::DIM_W-1:0] img_w_reg = 11'd1024;
  logic [imconv_pkg::DIM_W-1:0] img_h_reg = 11'd1024;
  logic [imconv_pkg::KSIZE_W-1:0] ksize_reg = 3'd3;
  logic [imconv_pkg::ROW_W-1:0] coef_rows [imconv_pkg::COEF_ROWS];
  logic [imconv_pkg::PIX_W-1:0] pixel_history [HIST_DEPTH];
  int pixels_in_frame = 0;
  int pixels_out_frame = 0;

  imconv_pkg::in_item_t pixel_feed[$];
  imconv_pkg::out_item_t filtered_expected[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;
  bit send_pause = 1'b0;
  int error_count = 0;
  int results_checked = 0;
  int frames_done = 0;
  int items_queued = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int eff_dim(logic [imconv_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Advance the predicted frame by one accepted item
  task automatic predict_filter_step(imconv_pkg::in_item_t it);
    int w, h, total, op, r, c, ks, n, sum;
    imconv_pkg::out_item_t res;
    w = eff_dim(img_w_reg);
    h = eff_dim(img_h_reg);
    total = w * h;
    op = pixels_out_frame;
    if (!it.drain && pixels_in_frame < total) begin
      pixel_history[pixels_in_frame % HIST_DEPTH] = it.pixel_in;
      pixels_in_frame++;
    end
    if (!(pixels_in_frame == total || pixels_in_frame >= op + HALF * w + HALF + 1))
      return;
    r = op / w;
    c = op % w;
    ks = int'(ksize_reg);
    res.pixel_out = pixel_history[op % HIST_DEPTH];
    if (ks % 2 == 1 && ks <= 5) begin
      n = ks / 2;
      if (r >= n && r + n < h && c >= n && c + n < w) begin
        sum = 0;
        for (int i = 0; i < ks; i++) begin
          for (int j = 0; j < ks; j++) begin
            sum += int'(pixel_history[((r + i - n) * w + (c + j - n)) % HIST_DEPTH]) *
                   int'(signed'(coef_rows[i][imconv_pkg::COEF_W*j +: imconv_pkg::COEF_W]));
          end
        end
        if (sum < 0) sum = 0;
        if (sum > (imconv_pkg::PIX_MAX << imconv_pkg::FRAC_BITS))
          sum = imconv_pkg::PIX_MAX << imconv_pkg::FRAC_BITS;
        res.pixel_out = imconv_pkg::PIX_W'((sum + (1 << (imconv_pkg::FRAC_BITS - 1)))
                                           >> imconv_pkg::FRAC_BITS);
      end
    end
    res.frame_end = (op + 1 >= total);
    if (res.frame_end) begin
      pixels_in_frame = 0;
      pixels_out_frame = 0;
    end else begin
      pixels_out_frame = op + 1;
    end
    filtered_expected.push_back(res);
  endtask

  // Driver: predict on acceptance, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_filter_step(in_data);
      if (!in_valid || !in_stall) begin
        if (pixel_feed.size() > 0 && !send_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data <= pixel_feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output item, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (filtered_expected.size() == 0) begin
        $display("%0t: unexpected output pixel=%0d frame_end=%0d", $time,
                 out_data.pixel_out, out_data.frame_end);
        error_count++;
      end else begin
        if (out_data.pixel_out !== filtered_expected[0].pixel_out ||
            out_data.frame_end !== filtered_expected[0].frame_end) begin
          $display("%0t: mismatch expected pixel=%0d frame_end=%0d, %s%0d frame_end=%0d",
                   $time, filtered_expected[0].pixel_out, filtered_expected[0].frame_end,
                   "actual pixel=", out_data.pixel_out, out_data.frame_end);
          error_count++;
        end
        if (filtered_expected[0].frame_end) frames_done++;
        void'(filtered_expected.pop_front());
        results_checked++;
      end
    end
    out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic [imconv_pkg::ROW_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      imconv_pkg::REG_IMAGE_WIDTH:  img_w_reg = val[imconv_pkg::DIM_W-1:0];
      imconv_pkg::REG_IMAGE_HEIGHT: img_h_reg = val[imconv_pkg::DIM_W-1:0];
      imconv_pkg::REG_KERNEL_SIZE:  ksize_reg = val[imconv_pkg::KSIZE_W-1:0];
      imconv_pkg::REG_KERNEL_ROW_0: coef_rows[0] = val;
      imconv_pkg::REG_KERNEL_ROW_1: coef_rows[1] = val;
      imconv_pkg::REG_KERNEL_ROW_2: coef_rows[2] = val;
      imconv_pkg::REG_KERNEL_ROW_3: coef_rows[3] = val;
      default:                      coef_rows[4] = val;
    endcase
  endtask

  // Random coefficient row: wild, small, or all one value
  function automatic logic [imconv_pkg::ROW_W-1:0] pick_row(int mode,
                                                           logic [imconv_pkg::COEF_W-1:0] fill);
    logic [imconv_pkg::ROW_W-1:0] row;
    row = {$urandom, $urandom};
    if (mode == 1) begin
      for (int j = 0; j < imconv_pkg::COEF_COLS; j++)
        row[imconv_pkg::COEF_W*j +: imconv_pkg::COEF_W] =
          imconv_pkg::COEF_W'($urandom_range(96) - 48);
    end else if (mode == 2) begin
      for (int j = 0; j < imconv_pkg::COEF_COLS; j++)
        row[imconv_pkg::COEF_W*j +: imconv_pkg::COEF_W] = fill;
    end
    return row;
  endfunction

  task automatic set_frame(int w, int h, int k, int mode,
                           logic [imconv_pkg::COEF_W-1:0] fill);
    write_reg(imconv_pkg::REG_IMAGE_WIDTH, imconv_pkg::ROW_W'(w));
    write_reg(imconv_pkg::REG_IMAGE_HEIGHT, imconv_pkg::ROW_W'(h));
    write_reg(imconv_pkg::REG_KERNEL_SIZE, imconv_pkg::ROW_W'(k));
    write_reg(imconv_pkg::REG_KERNEL_ROW_0, pick_row(mode, fill));
    write_reg(imconv_pkg::REG_KERNEL_ROW_1, pick_row(mode, fill));
    write_reg(imconv_pkg::REG_KERNEL_ROW_2, pick_row(mode, fill));
    write_reg(imconv_pkg::REG_KERNEL_ROW_3, pick_row(mode, fill));
    write_reg(imconv_pkg::REG_KERNEL_ROW_4, pick_row(mode, fill));
  endtask

  // Queue one whole frame; add just enough tail items to flush it
  task automatic queue_frame(int drain_pct, int pix_mode);
    int w, h, total, avail, op, lag;
    imconv_pkg::in_item_t it;
    w = eff_dim(img_w_reg);
    h = eff_dim(img_h_reg);
    total = w * h;
    lag = HALF * w + HALF;
    avail = 0;
    op = 0;
    while (op < total) begin
      it.drain = (avail == total) ? ($urandom_range(99) < 70) :
                 ($urandom_range(99) < drain_pct);
      case (pix_mode)
        0: it.pixel_in = $urandom_range(1) ? 8'hFF : 8'h00;
        default: it.pixel_in = $urandom;
      endcase
      pixel_feed.push_back(it);
      items_queued++;
      if (!it.drain && avail < total) avail++;
      if (avail == total || avail >= op + lag + 1) op++;
    end
  endtask

  task automatic wait_idle();
    while (pixel_feed.size() > 0 || in_valid || filtered_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_frames(int target);
    int start;
    start = items_queued;
    while (items_queued - start < target) begin
      set_frame($urandom_range(12, 1), $urandom_range(8, 1), $urandom_range(7),
                $urandom_range(2), imconv_pkg::COEF_W'($urandom));
      queue_frame($urandom_range(20), $urandom_range(3));
      wait_idle();
    end
  endtask

  initial begin
    for (int i = 0; i < imconv_pkg::COEF_ROWS; i++) coef_rows[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) pixel_history[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: saturating kernels on extreme pixels, then a pass-through kernel size
    set_frame(5, 5, 5, 2, 12'h7FF);
    queue_frame(10, 0);
    wait_idle();
    set_frame(3, 3, 3, 2, 12'h800);
    queue_frame(10, 0);
    wait_idle();
    set_frame(2, 2, 4, 2, 12'h100);
    queue_frame(0, 1);
    wait_idle();

    // Random frames under three idling patterns
    send_idle_pct = 18;
    recv_idle_pct = 73;
    random_frames(120);
    send_idle_pct = 73;
    recv_idle_pct = 18;
    random_frames(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(120);

    // Hold the output a long while so the unit backs up and stalls its input
    set_frame(12, 8, 5, 1, '0);
    queue_frame(0, 1);
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    wait_idle();

    // Pause the sender mid-frame until every pending result is out
    set_frame(9, 7, 3, 1, '0);
    queue_frame(5, 1);
    repeat (50) @(posedge clk);
    send_pause = 1'b1;
    while (filtered_expected.size() > 0) @(posedge clk);
    send_pause = 1'b0;
    wait_idle();

    // Degenerate sizes: zero registers, single row and single column frames
    send_idle_pct = 10;
    recv_idle_pct = 10;
    set_frame(0, 0, 7, 0, '0);
    queue_frame(0, 1);
    wait_idle();
    set_frame(1, 8, 3, 1, '0);
    queue_frame(2, 1);
    wait_idle();
    set_frame(8, 1, 5, 1, '0);
    queue_frame(2, 1);
    wait_idle();
    set_frame(6, 0, 1, 1, '0);
    queue_frame(2, 1);
    wait_idle();

    $display("Covered %0d items in %0d frames, %0d output pixels checked.",
             items_queued, frames_done, results_checked);
    $display("Frames from 1x1 to 12x8 with zero sizes, kernel sizes 0 to 7, random stalls.");
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #20ms;
    $display("Timeout with %0d results still expected.", filtered_expected.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
